// ===== hdl/tbps_pkg.sv =====
// Package for the three-band pole splitter: widths, register indexes and the
// saturation helpers shared by the datapath.
// Depends on nothing.
package tbps_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int COEFF_BITS   = 17;
	localparam int COEFF_FRAC   = 16;
	localparam int STAGE_BITS   = 32;
	localparam int NUM_STAGES   = 4;
	localparam int DELAY_TAPS   = 3;
	localparam int NUM_CHANNELS = 2;

	// Derived widths.
	localparam int CH_BITS     = $clog2(NUM_CHANNELS);
	localparam int STG_BITS    = $clog2(2 * NUM_STAGES);
	localparam int TAP_BITS    = $clog2(DELAY_TAPS);
	localparam int DIFF_BITS   = STAGE_BITS + 1;
	localparam int PROD_BITS   = COEFF_BITS + 1 + DIFF_BITS;
	localparam int STEP_BITS   = PROD_BITS - COEFF_FRAC;
	localparam int SUM_BITS    = STEP_BITS + 1;
	localparam int BAND_BITS   = STAGE_BITS + 1;
	localparam int ST_DEPTH    = NUM_CHANNELS * 2 * NUM_STAGES;
	localparam int DLY_DEPTH   = NUM_CHANNELS * (2 ** TAP_BITS);

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_COEFF = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_COEFF = 2'd1;

	typedef logic signed [STAGE_BITS-1:0]  stage_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Clamp a stage sum to the signed stage range.
	function automatic stage_t sat_stage(input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-STAGE_BITS:0] top;
		stage_t res;
		top = v[SUM_BITS-1:STAGE_BITS-1];
		if ((&top) || !(|top)) begin
			res = v[STAGE_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			res = {1'b1, {(STAGE_BITS-1){1'b0}}};
		end else begin
			res = {1'b0, {(STAGE_BITS-1){1'b1}}};
		end
		return res;
	endfunction

	// Clamp a band value to the signed sample range.
	function automatic sample_t sat_sample(input logic signed [BAND_BITS-1:0] v);
		logic [BAND_BITS-SAMPLE_BITS:0] top;
		sample_t res;
		top = v[BAND_BITS-1:SAMPLE_BITS-1];
		if ((&top) || !(|top)) begin
			res = v[SAMPLE_BITS-1:0];
		end else if (v[BAND_BITS-1]) begin
			res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

// ===== hdl/three_band_pole_splitter.sv =====
// A new item is accepted only in the idle state, so the block takes no new item
// until the last one is loaded into the output register; the eight one-pole updates
// share one multiplier and the stage memory, which has one read and one write port.
// Reset clears the sequencer, the coefficients, the delay pointers and the
// valid bits of both state memories; entries not yet written read as zero.
// No clearing pass is needed, so items are taken right after reset.
// Three-band splitter top level: sequencer, stage memory, delay memory and
// the shared multiply-round-saturate datapath. Depends on tbps_pkg.
module three_band_pole_splitter
	import tbps_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [COEFF_BITS-1:0]         cfg_data,
	// Input stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [SAMPLE_BITS-1:0]        s_axis_tdata,   // sample
	input  logic [0:0]                    s_axis_tuser,   // channel_select
	// Result stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [3*SAMPLE_BITS-1:0]      m_axis_tdata,   // low_band, high_band, mid_band
	output logic [0:0]                    m_axis_tuser    // channel_out
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD0  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	localparam logic [STG_BITS-1:0] STG_LAST_LOWER = STG_BITS'(NUM_STAGES - 1);
	localparam logic [STG_BITS-1:0] STG_LAST       = STG_BITS'(2 * NUM_STAGES - 1);
	localparam logic [TAP_BITS-1:0] TAP_LAST       = TAP_BITS'(DELAY_TAPS - 1);

	logic [1:0]                 state_q;
	logic [STG_BITS-1:0]        stg_q;
	logic [CH_BITS-1:0]         ch_q;
	logic                       sel_q;
	sample_t                    x_q;
	stage_t                     prev_q;
	stage_t                     stage_q;
	stage_t                     lo_q;
	logic signed [PROD_BITS-1:0] p_q;
	logic [COEFF_BITS-1:0]      lower_coeff_q;
	logic [COEFF_BITS-1:0]      upper_coeff_q;
	logic [TAP_BITS-1:0]        dly_ptr_q [NUM_CHANNELS];

	// Stage memory and its valid bits.
	stage_t                     st_mem [ST_DEPTH];
	logic [ST_DEPTH-1:0]        st_vld_q;
	stage_t                     st_rd_q;
	logic                       st_rd_vld_q;
	logic                       st_rd_en;
	logic [CH_BITS+STG_BITS-1:0] st_rd_addr;
	logic                       st_we;
	logic [CH_BITS+STG_BITS-1:0] st_wr_addr;

	// Delay memory and its valid bits.
	sample_t                    dly_mem [DLY_DEPTH];
	logic [DLY_DEPTH-1:0]       dly_vld_q;
	sample_t                    dly_rd_q;
	logic                       dly_rd_vld_q;
	logic [CH_BITS+TAP_BITS-1:0] dly_addr;

	logic                       out_vld_q;
	logic                       out_sel_q;
	sample_t                    low_q;
	sample_t                    high_q;
	sample_t                    mid_q;

	logic                       in_xfer;
	logic                       out_free;
	logic                       last_wr;
	logic                       advance;
	stage_t                     stage_old;
	logic signed [DIFF_BITS-1:0] diff;
	logic [COEFF_BITS-1:0]      coeff;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] rounded;
	logic signed [STEP_BITS-1:0] step;
	logic signed [SUM_BITS-1:0] sum;
	stage_t                     stage_new;
	sample_t                    oldest;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign last_wr       = (state_q == ST_WR) && (stg_q == STG_LAST);
	// The last stage waits until the output register can take the result.
	assign advance       = (state_q == ST_WR) && (!last_wr || out_free);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_coeff_q <= '0;
			upper_coeff_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOWER_COEFF: lower_coeff_q <= cfg_data;
				REG_UPPER_COEFF: upper_coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: one read ahead, then a multiply state and a write state per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stg_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					stg_q <= '0;
					if (in_xfer) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WR;
				ST_WR: begin
					if (advance) begin
						if (last_wr) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MUL;
							stg_q   <= stg_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item registers: channel, sample and the drive of the next stage.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sel_q  <= s_axis_tuser[0];
			ch_q   <= CH_BITS'(s_axis_tuser[0]);
			x_q    <= s_axis_tdata;
			prev_q <= STAGE_BITS'(signed'(s_axis_tdata));
		end else if (advance) begin
			if (stg_q == STG_LAST_LOWER) begin
				prev_q <= STAGE_BITS'(x_q);
				lo_q   <= stage_new;
			end else begin
				prev_q <= stage_new;
			end
		end
	end

	// Stage memory addressing: stage i+1 is read while stage i is written.
	assign st_rd_en   = (state_q == ST_RD0) || (advance && !last_wr);
	assign st_rd_addr = (state_q == ST_RD0) ? {ch_q, {STG_BITS{1'b0}}}
	                                        : {ch_q, stg_q + 1'b1};
	assign st_we      = (state_q == ST_WR);
	assign st_wr_addr = {ch_q, stg_q};

	always_ff @(posedge clk) begin
		if (st_rd_en) begin
			st_rd_q <= st_mem[st_rd_addr];
		end
		if (st_we) begin
			st_mem[st_wr_addr] <= stage_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q    <= '0;
			st_rd_vld_q <= 1'b0;
		end else begin
			if (st_rd_en) begin
				st_rd_vld_q <= st_vld_q[st_rd_addr];
			end
			if (st_we) begin
				st_vld_q[st_wr_addr] <= 1'b1;
			end
		end
	end

	// Delay line as a ring per channel: the oldest tap is read and replaced.
	assign dly_addr = {ch_q, dly_ptr_q[ch_q]};

	always_ff @(posedge clk) begin
		if (state_q == ST_RD0) begin
			dly_rd_q         <= dly_mem[dly_addr];
			dly_mem[dly_addr] <= x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_q    <= '0;
			dly_rd_vld_q <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				dly_ptr_q[c] <= '0;
			end
		end else if (state_q == ST_RD0) begin
			dly_rd_vld_q        <= dly_vld_q[dly_addr];
			dly_vld_q[dly_addr] <= 1'b1;
			dly_ptr_q[ch_q]     <= (dly_ptr_q[ch_q] == TAP_LAST) ? '0
			                                                   : dly_ptr_q[ch_q] + 1'b1;
		end
	end

	assign oldest = dly_rd_vld_q ? dly_rd_q : '0;

	// Multiply cycle: difference to the drive times the cascade coefficient.
	assign stage_old = st_rd_vld_q ? st_rd_q : '0;
	assign diff      = DIFF_BITS'(prev_q) - DIFF_BITS'(stage_old);
	assign coeff     = stg_q[STG_BITS-1] ? upper_coeff_q : lower_coeff_q;
	assign prod      = PROD_BITS'(signed'({1'b0, coeff})) * PROD_BITS'(diff);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			p_q     <= prod;
			stage_q <= stage_old;
		end
	end

	// Write cycle: round half up, drop the fraction, accumulate and saturate.
	assign rounded   = p_q + PROD_BITS'(1 << (COEFF_FRAC - 1));
	assign step      = rounded[PROD_BITS-1:COEFF_FRAC];
	assign sum       = SUM_BITS'(stage_q) + SUM_BITS'(step);
	assign stage_new = sat_stage(sum);

	// Output register, loaded when the last upper stage is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (last_wr && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_wr && out_free) begin
			out_sel_q <= sel_q;
			low_q     <= sat_sample(BAND_BITS'(lo_q));
			high_q    <= sat_sample(BAND_BITS'(oldest) - BAND_BITS'(stage_new));
			mid_q     <= sat_sample(BAND_BITS'(stage_new) - BAND_BITS'(lo_q));
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {mid_q, high_q, low_q};
	assign m_axis_tuser  = out_sel_q;

endmodule

// ===== test/three_band_pole_splitter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the three-band pole splitter: a directed table
// followed by random stereo traffic, checked against a bit-exact predictor.
// Depends on tbps_pkg and the three_band_pole_splitter top level.
module three_band_pole_splitter_tb;
	import tbps_pkg::*;

	// Register indexes that the block must ignore.
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_B = 2'd3;

	localparam logic [COEFF_BITS-1:0]  COEFF_MAX   = {COEFF_BITS{1'b1}};
	localparam logic [COEFF_BITS-1:0]  COEFF_UNITY = 17'h10000;
	localparam logic [SAMPLE_BITS-1:0] SMP_MAX     = 24'h7FFFFF;
	localparam logic [SAMPLE_BITS-1:0] SMP_MIN     = 24'h800000;

	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int ITEMS_PER_SET = 89;

	// One result: channel and the three bands.
	typedef struct packed {
		logic                   ch;
		logic [SAMPLE_BITS-1:0] low;
		logic [SAMPLE_BITS-1:0] high;
		logic [SAMPLE_BITS-1:0] mid;
	} band_t;

	// One row of the directed table: a register write or a sample.
	typedef struct packed {
		logic                      is_cfg;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [COEFF_BITS-1:0]     val;
		logic                      ch;
		logic [SAMPLE_BITS-1:0]    smp;
		logic                      typed;
		band_t                     want;
	} row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_BITS-1:0]  cfg_index;
	logic [COEFF_BITS-1:0]      cfg_data;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [SAMPLE_BITS-1:0]     s_axis_tdata;   // sample
	logic [0:0]                 s_axis_tuser;   // channel_select
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [3*SAMPLE_BITS-1:0]   m_axis_tdata;   // low_band, high_band, mid_band
	logic [0:0]                 m_axis_tuser;   // channel_out

	// Predictor state: coefficients, delay line and both cascades per channel.
	logic [COEFF_BITS-1:0]  lower_k;
	logic [COEFF_BITS-1:0]  upper_k;
	sample_t                tap_line [NUM_CHANNELS][DELAY_TAPS];
	stage_t                 lower_pole [NUM_CHANNELS][NUM_STAGES];
	stage_t                 upper_pole [NUM_CHANNELS][NUM_STAGES];

	band_t                  pending_bands [$];
	row_t                   dir_rows [$];
	int                     errors = 0;
	int                     send_idle_pct = 0;
	int                     recv_idle_pct = 0;
	int                     hold_requests = 0;
	int                     hold_served = 0;
	int                     hold_left = 0;
	int                     quiet_cycles = 0;

	three_band_pole_splitter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// One-pole update: stage += round(coeff * (drive - stage) / 2^16), saturated.
	function automatic stage_t pole_update(stage_t st, longint drive,
			logic [COEFF_BITS-1:0] k);
		longint d;
		longint p;
		longint q;
		longint n;
		d = drive - longint'(st);
		p = $signed({47'd0, k}) * d;
		q = (p + 64'sd32768) >>> COEFF_FRAC;
		n = longint'(st) + q;
		if (n > 64'sd2147483647) begin
			n = 64'sd2147483647;
		end else if (n < -64'sd2147483648) begin
			n = -64'sd2147483648;
		end
		return n[STAGE_BITS-1:0];
	endfunction

	// Clamp an exact band value to the signed sample range.
	function automatic logic [SAMPLE_BITS-1:0] clamp_band(longint v);
		if (v > 64'sd8388607) begin
			return SMP_MAX;
		end else if (v < -64'sd8388608) begin
			return SMP_MIN;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	// Advance the predictor by one sample and return the three bands.
	function automatic band_t predict_bands(logic ch, logic [SAMPLE_BITS-1:0] smp);
		band_t  res;
		longint drive;
		longint oldest;
		longint lo;
		longint up;
		int     i;
		oldest = longint'(tap_line[ch][DELAY_TAPS-1]);
		for (i = DELAY_TAPS - 1; i > 0; i--) begin
			tap_line[ch][i] = tap_line[ch][i-1];
		end
		tap_line[ch][0] = smp;
		drive = longint'(sample_t'(smp));
		for (i = 0; i < NUM_STAGES; i++) begin
			lower_pole[ch][i] = pole_update(lower_pole[ch][i], drive, lower_k);
			drive = longint'(lower_pole[ch][i]);
		end
		drive = longint'(sample_t'(smp));
		for (i = 0; i < NUM_STAGES; i++) begin
			upper_pole[ch][i] = pole_update(upper_pole[ch][i], drive, upper_k);
			drive = longint'(upper_pole[ch][i]);
		end
		lo = longint'(lower_pole[ch][NUM_STAGES-1]);
		up = longint'(upper_pole[ch][NUM_STAGES-1]);
		res.ch   = ch;
		res.low  = clamp_band(lo);
		res.high = clamp_band(oldest - up);
		res.mid  = clamp_band(up - lo);
		return res;
	endfunction

	// Register write: only once every expected result has arrived.
	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [COEFF_BITS-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_bands.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LOWER_COEFF) begin
			lower_k = val;
		end else if (idx == REG_UPPER_COEFF) begin
			upper_k = val;
		end
	endtask

	// Offer one sample, with random idle cycles ahead of it.
	task automatic push_sample(logic ch, logic [SAMPLE_BITS-1:0] smp, logic typed,
			band_t want);
		band_t guess;
		// Close any configuration transfer still offered.
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= ch;
		do @(posedge clk); while (!s_axis_tready);
		guess = predict_bands(ch, smp);
		pending_bands.push_back(typed ? want : guess);
	endtask

	task automatic add_item(logic ch, logic [SAMPLE_BITS-1:0] smp, logic typed,
			logic [SAMPLE_BITS-1:0] lo, logic [SAMPLE_BITS-1:0] hi,
			logic [SAMPLE_BITS-1:0] mid);
		row_t r;
		r = '0;
		r.ch = ch;
		r.smp = smp;
		r.typed = typed;
		r.want = '{ch: ch, low: lo, high: hi, mid: mid};
		dir_rows.push_back(r);
	endtask

	task automatic add_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [COEFF_BITS-1:0] val);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		dir_rows.push_back(r);
	endtask

	function automatic logic [COEFF_BITS-1:0] pick_coeff();
		case ($urandom_range(4))
			0: return COEFF_BITS'($urandom_range(0, 8192));
			1: return COEFF_BITS'($urandom_range(0, 65536));
			2: return COEFF_BITS'($urandom_range(0, 131071));
			3: return COEFF_UNITY;
			default: return $urandom_range(1) ? COEFF_MAX : '0;
		endcase
	endfunction

	// Result side: check each transfer against the oldest expectation.
	always @(posedge clk) begin : rx_side
		band_t want;
		band_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{ch: m_axis_tuser[0], low: m_axis_tdata[SAMPLE_BITS-1:0],
				high: m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
				mid: m_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]};
			if (pending_bands.size() == 0) begin
				$display("%0t ERROR unexpected result: expected none, actual ch %0d low %0d",
					$time, got.ch, $signed(got.low));
				errors++;
			end else begin
				want = pending_bands.pop_front();
				if (got.ch !== want.ch) begin
					$display("%0t ERROR channel_out: expected %0d, actual %0d",
						$time, want.ch, got.ch);
					errors++;
				end
				if (got.low !== want.low) begin
					$display("%0t ERROR low_band: expected %0d, actual %0d",
						$time, $signed(want.low), $signed(got.low));
					errors++;
				end
				if (got.high !== want.high) begin
					$display("%0t ERROR high_band: expected %0d, actual %0d",
						$time, $signed(want.high), $signed(got.high));
					errors++;
				end
				if (got.mid !== want.mid) begin
					$display("%0t ERROR mid_band: expected %0d, actual %0d",
						$time, $signed(want.mid), $signed(got.mid));
					errors++;
				end
			end
		end
		// A requested hold-off keeps the result side closed for a long stretch.
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("** three_band_pole_splitter: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : main_seq
		logic [SAMPLE_BITS-1:0] last_smp [NUM_CHANNELS];
		logic [SAMPLE_BITS-1:0] smp;
		logic                   ch;
		int                     phase;
		int                     set;
		int                     n;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		lower_k = '0;
		upper_k = '0;
		for (n = 0; n < NUM_CHANNELS; n++) begin
			last_smp[n] = '0;
			for (set = 0; set < DELAY_TAPS; set++) tap_line[n][set] = '0;
			for (set = 0; set < NUM_STAGES; set++) begin
				lower_pole[n][set] = '0;
				upper_pole[n][set] = '0;
			end
		end

		// Coefficients are zero after reset: both cascades stay at zero and the
		// high band is the plain input three samples back on the same channel.
		add_item(1'b0, SMP_MAX,     1'b1, '0, '0, '0);
		add_item(1'b1, SMP_MIN,     1'b1, '0, '0, '0);
		add_item(1'b0, SMP_MIN,     1'b1, '0, '0, '0);
		add_item(1'b1, SMP_MAX,     1'b1, '0, '0, '0);
		add_item(1'b0, 24'h000001,  1'b1, '0, '0, '0);
		add_item(1'b1, 24'hFFFFFF,  1'b1, '0, '0, '0);
		add_item(1'b0, 24'h123456,  1'b1, '0, SMP_MAX, '0);
		add_item(1'b1, 24'h000000,  1'b1, '0, SMP_MIN, '0);
		add_item(1'b0, 24'h000000,  1'b1, '0, SMP_MIN, '0);
		add_item(1'b1, 24'h000000,  1'b1, '0, SMP_MAX, '0);
		// Writes to unknown indexes must leave both coefficients at zero.
		add_cfg(REG_UNUSED_A, COEFF_MAX);
		add_cfg(REG_UNUSED_B, COEFF_MAX);
		add_item(1'b0, 24'hABCDEF,  1'b1, '0, 24'h000001, '0);
		add_item(1'b1, 24'h5A5A5A,  1'b1, '0, 24'hFFFFFF, '0);
		// Unity coefficient: every stage follows the input at once.
		add_cfg(REG_LOWER_COEFF, COEFF_UNITY);
		add_cfg(REG_UPPER_COEFF, COEFF_UNITY);
		add_item(1'b0, SMP_MAX, 1'b0, '0, '0, '0);
		add_item(1'b0, SMP_MIN, 1'b0, '0, '0, '0);
		add_item(1'b1, SMP_MIN, 1'b0, '0, '0, '0);
		// Largest coefficient: unstable stages held by stage saturation.
		add_cfg(REG_LOWER_COEFF, COEFF_MAX);
		add_cfg(REG_UPPER_COEFF, COEFF_MAX);
		add_item(1'b0, SMP_MAX, 1'b0, '0, '0, '0);
		add_item(1'b0, SMP_MIN, 1'b0, '0, '0, '0);
		add_item(1'b0, SMP_MAX, 1'b0, '0, '0, '0);
		add_item(1'b1, SMP_MIN, 1'b0, '0, '0, '0);
		add_item(1'b1, SMP_MIN, 1'b0, '0, '0, '0);
		// Lower cascade off, upper at its largest: full-scale mid band.
		add_cfg(REG_LOWER_COEFF, '0);
		add_item(1'b0, 24'h400000, 1'b0, '0, '0, '0);
		add_item(1'b1, 24'hC00000, 1'b0, '0, '0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		send_idle_pct = 13;
		recv_idle_pct = 81;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				cfg_write(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				push_sample(dir_rows[i].ch, dir_rows[i].smp, dir_rows[i].typed,
					dir_rows[i].want);
			end
		end

		// Random traffic in three idling modes, new coefficients per set.
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 81 : 0;
			recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 13 : 0;
			for (set = 0; set < 3; set++) begin
				cfg_write(REG_LOWER_COEFF, pick_coeff());
				cfg_write(REG_UPPER_COEFF, pick_coeff());
				if ($urandom_range(3) == 0) begin
					cfg_write($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B,
						COEFF_BITS'($urandom_range(0, 131071)));
				end
				// Fill the block while the result side is held off.
				if (phase == 0 && set == 0) hold_requests++;
				for (n = 0; n < ITEMS_PER_SET; n++) begin
					ch = 1'($urandom_range(1));
					case ($urandom_range(5))
						0: smp = SAMPLE_BITS'($urandom);
						1: smp = {{14{1'b0}}, 10'($urandom)} - 24'd512;
						2: smp = $urandom_range(1) ? SMP_MAX : SMP_MIN;
						default: smp = ($urandom_range(3) == 0) ? 24'($urandom)
							: last_smp[ch];
					endcase
					last_smp[ch] = smp;
					push_sample(ch, smp, 1'b0, '0);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then let the pipeline settle.
		while (pending_bands.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("** three_band_pole_splitter: PASSED **");
		end else begin
			$display("** three_band_pole_splitter: FAILED **");
		end
		$finish;
	end

endmodule
